@@ rtl/allocation_bitmap_engine_defines.svh @@
// Assertion macros used by the allocation bitmap engine RTL.
`ifndef ALLOCATION_BITMAP_ENGINE_DEFINES_SVH
`define ALLOCATION_BITMAP_ENGINE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define ABE_ASSERT_IMPLY(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("allocation bitmap engine: same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define ABE_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("allocation bitmap engine: next-cycle check failed");

`endif

@@ rtl/abe_pkg.sv @@
// Types, constants and command codes of the allocation bitmap engine.
`default_nettype none

package abe_pkg;

  localparam int MAP_BITS   = 1024;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = 16;
  localparam int WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int BIDX_W     = $clog2(WORD_BITS);
  localparam int STEP_W     = $clog2(BIDX_W);
  localparam int POS_W      = 11;
  localparam int CMD_W      = 3;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WIDX_W-1:0]    widx_t;
  typedef logic [BIDX_W-1:0]    bidx_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [CMD_W-1:0]     cmd_t;

  localparam cmd_t CMD_TEST_BIT    = 3'd0;
  localparam cmd_t CMD_SET_BIT     = 3'd1;
  localparam cmd_t CMD_CLEAR_BIT   = 3'd2;
  localparam cmd_t CMD_SET_RANGE   = 3'd3;
  localparam cmd_t CMD_CLEAR_RANGE = 3'd4;
  localparam cmd_t CMD_ZERO_TEST   = 3'd5;
  localparam cmd_t CMD_FIND_LAST   = 3'd6;

  typedef struct packed {
    cmd_t command;
    pos_t start_position;
    pos_t end_position;
  } request_t;

  typedef struct packed {
    logic flag;
    pos_t found_position;
    logic position_error;
  } result_t;

  // Word span and edge offsets of the bits a command touches.
  typedef struct packed {
    widx_t first;
    widx_t last;
    bidx_t lo;
    bidx_t hi;
  } mask_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEARCH,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/allocation_bitmap_engine.sv @@
// Allocation bitmap engine: 1024-bit map, 16 words of 64 bits, MSB-first bit numbering.
// Bit commands: read the word, apply the command, strobe; busy through it, next command in the cycle after.
// Range set/clear/zero-test: one memory word per cycle across the span, then the strobe.
// Find last set: scan words downward; on a hit, a trailing-zero search in that word, then the strobe.
// Bad positions, empty ranges and unused codes answer in the cycle after accept.
// Synchronous active-high reset empties the map at once; the receiver cannot stall.
`default_nettype none

`include "allocation_bitmap_engine_defines.svh"

module allocation_bitmap_engine (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire abe_pkg::request_t request,
  output logic                  busy,
  output logic                  done,
  output abe_pkg::result_t      result
);

  abe_pkg::state_t    state, state_next;
  abe_pkg::cmd_t      op, op_next;
  abe_pkg::mask_ctl_t ctl, ctl_next;
  logic               desc, desc_next;
  abe_pkg::widx_t     rd_addr, rd_addr_next;
  logic               rd_left, rd_left_next;
  logic               pv;
  abe_pkg::widx_t     pw;
  abe_pkg::widx_t     fw, fw_next;
  logic               flag, flag_next;
  abe_pkg::pos_t      found, found_next;
  logic               err, err_next;

  logic               accept;
  abe_pkg::pos_t      s_sat, e_sat, e_m1;
  logic               empty;
  abe_pkg::widx_t     s_word, e_word;
  abe_pkg::bidx_t     s_off, e_off;

  logic               rd_en;
  abe_pkg::word_t     rd_data;
  logic               wr_en;
  abe_pkg::word_t     wr_data;
  abe_pkg::word_t     mask;
  logic               hit;
  logic               last_word;
  logic               find_hit;
  logic               tz_done;
  abe_pkg::bidx_t     tz_count;

  assign accept = start && !busy;

  // Saturate bounds and split positions into word index and offset.
  always_comb begin
    s_sat  = (request.start_position > abe_pkg::pos_t'(abe_pkg::MAP_BITS))
             ? abe_pkg::pos_t'(abe_pkg::MAP_BITS) : request.start_position;
    e_sat  = (request.end_position > abe_pkg::pos_t'(abe_pkg::MAP_BITS))
             ? abe_pkg::pos_t'(abe_pkg::MAP_BITS) : request.end_position;
    e_m1   = e_sat - 1'b1;
    empty  = e_sat <= s_sat;
    s_word = s_sat[abe_pkg::BIDX_W +: abe_pkg::WIDX_W];
    e_word = e_m1[abe_pkg::BIDX_W +: abe_pkg::WIDX_W];
    s_off  = s_sat[abe_pkg::BIDX_W-1:0];
    e_off  = e_m1[abe_pkg::BIDX_W-1:0];
  end

  abe_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pw),
    .wr_data (wr_data)
  );

  abe_mask u_mask (
    .ctl      (ctl),
    .word_idx (pw),
    .mask     (mask)
  );

  abe_tz u_tz (
    .clk   (clk),
    .rst   (rst),
    .load  (find_hit),
    .word  (rd_data),
    .done  (tz_done),
    .count (tz_count)
  );

  // Decode the word now leaving the memory.
  always_comb begin
    hit       = (rd_data & mask) != '0;
    last_word = (state == abe_pkg::ST_SCAN) && pv && (pw == ctl.last);
    find_hit  = (state == abe_pkg::ST_SCAN) && pv && (op == abe_pkg::CMD_FIND_LAST) && hit;
    rd_en     = (state == abe_pkg::ST_SCAN) && rd_left;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      abe_pkg::ST_IDLE: begin
        if (accept) begin
          case (request.command)
            abe_pkg::CMD_TEST_BIT, abe_pkg::CMD_SET_BIT, abe_pkg::CMD_CLEAR_BIT: begin
              state_next = (request.start_position >= abe_pkg::pos_t'(abe_pkg::MAP_BITS))
                           ? abe_pkg::ST_DONE : abe_pkg::ST_SCAN;
            end
            abe_pkg::CMD_SET_RANGE, abe_pkg::CMD_CLEAR_RANGE, abe_pkg::CMD_ZERO_TEST: begin
              state_next = empty ? abe_pkg::ST_DONE : abe_pkg::ST_SCAN;
            end
            abe_pkg::CMD_FIND_LAST: begin
              state_next = abe_pkg::ST_SCAN;
            end
            default: begin
              state_next = abe_pkg::ST_DONE;
            end
          endcase
        end
      end
      abe_pkg::ST_SCAN: begin
        if (find_hit) begin
          state_next = abe_pkg::ST_SEARCH;
        end else if (last_word) begin
          state_next = abe_pkg::ST_DONE;
        end
      end
      abe_pkg::ST_SEARCH: begin
        if (tz_done) begin
          state_next = abe_pkg::ST_DONE;
        end
      end
      abe_pkg::ST_DONE: begin
        state_next = abe_pkg::ST_IDLE;
      end
      default: begin
        state_next = abe_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath next values and memory write.
  always_comb begin
    op_next      = op;
    ctl_next     = ctl;
    desc_next    = desc;
    rd_addr_next = rd_addr;
    rd_left_next = rd_left;
    fw_next      = fw;
    flag_next    = flag;
    found_next   = found;
    err_next     = err;
    wr_en        = 1'b0;
    wr_data      = rd_data | mask;

    if (state == abe_pkg::ST_IDLE && accept) begin
      op_next      = request.command;
      flag_next    = 1'b0;
      found_next   = '0;
      err_next     = 1'b0;
      desc_next    = 1'b0;
      rd_left_next = 1'b1;
      rd_addr_next = s_word;
      ctl_next     = '{first: s_word, last: e_word, lo: s_off, hi: e_off};
      case (request.command)
        abe_pkg::CMD_TEST_BIT, abe_pkg::CMD_SET_BIT, abe_pkg::CMD_CLEAR_BIT: begin
          err_next = request.start_position >= abe_pkg::pos_t'(abe_pkg::MAP_BITS);
          ctl_next = '{first: s_word, last: s_word, lo: s_off, hi: s_off};
        end
        abe_pkg::CMD_ZERO_TEST: begin
          flag_next = 1'b1;
        end
        abe_pkg::CMD_FIND_LAST: begin
          desc_next    = 1'b1;
          rd_addr_next = abe_pkg::widx_t'(abe_pkg::WORD_COUNT - 1);
          ctl_next     = '{first: abe_pkg::widx_t'(abe_pkg::WORD_COUNT - 1),
                           last:  '0,
                           lo:    '0,
                           hi:    abe_pkg::bidx_t'(abe_pkg::WORD_BITS - 1)};
        end
        default: begin
          flag_next = 1'b0;
        end
      endcase
    end

    // Issue one read per cycle across the span.
    if (rd_en) begin
      rd_addr_next = desc ? rd_addr - 1'b1 : rd_addr + 1'b1;
      rd_left_next = rd_addr != ctl.last;
    end

    // Apply the command to the word read last cycle.
    if (state == abe_pkg::ST_SCAN && pv) begin
      case (op)
        abe_pkg::CMD_TEST_BIT: begin
          flag_next = hit;
        end
        abe_pkg::CMD_SET_BIT: begin
          flag_next = !hit;
          wr_en     = 1'b1;
          wr_data   = rd_data | mask;
        end
        abe_pkg::CMD_CLEAR_BIT: begin
          flag_next = hit;
          wr_en     = 1'b1;
          wr_data   = rd_data & ~mask;
        end
        abe_pkg::CMD_SET_RANGE: begin
          wr_en   = 1'b1;
          wr_data = rd_data | mask;
        end
        abe_pkg::CMD_CLEAR_RANGE: begin
          wr_en   = 1'b1;
          wr_data = rd_data & ~mask;
        end
        abe_pkg::CMD_ZERO_TEST: begin
          if (hit) begin
            flag_next = 1'b0;
          end
        end
        abe_pkg::CMD_FIND_LAST: begin
          if (hit) begin
            fw_next      = pw;
            rd_left_next = 1'b0;
          end
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end

    // Turn the trailing-zero count into position plus one.
    if (state == abe_pkg::ST_SEARCH && tz_done) begin
      found_next = abe_pkg::pos_t'({fw, abe_pkg::bidx_t'(0)})
                 + abe_pkg::pos_t'(abe_pkg::WORD_BITS)
                 - abe_pkg::pos_t'(tz_count);
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= abe_pkg::ST_IDLE;
      rd_left <= 1'b0;
      pv      <= 1'b0;
    end else begin
      state   <= state_next;
      rd_left <= rd_left_next;
      pv      <= rd_en;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op      <= op_next;
    ctl     <= ctl_next;
    desc    <= desc_next;
    rd_addr <= rd_addr_next;
    pw      <= rd_addr;
    fw      <= fw_next;
    flag    <= flag_next;
    found   <= found_next;
    err     <= err_next;
  end

  // Outputs.
  always_comb begin
    busy   = state != abe_pkg::ST_IDLE;
    done   = state == abe_pkg::ST_DONE;
    result = '{flag: flag, found_position: found, position_error: err};
  end

  `ABE_ASSERT_IMPLY(a_done_busy, clk, rst, done, busy)
  `ABE_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy)
  `ABE_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `ABE_ASSERT_IMPLY(a_err_clean, clk, rst, done && err, !flag && found == '0)
  `ABE_ASSERT_IMPLY(a_tz_in_search, clk, rst, tz_done, state == abe_pkg::ST_SEARCH)

endmodule

`default_nettype wire

@@ rtl/abe_store.sv @@
// Bitmap word memory with per-word valid bits that read as zero after reset.
`default_nettype none

module abe_store (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           rd_en,
  input  wire abe_pkg::widx_t rd_addr,
  output abe_pkg::word_t      rd_data,
  input  wire logic           wr_en,
  input  wire abe_pkg::widx_t wr_addr,
  input  wire abe_pkg::word_t wr_data
);

  abe_pkg::word_t                  mem [abe_pkg::WORD_COUNT];
  logic [abe_pkg::WORD_COUNT-1:0]  valid;

  // Write the word array.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Mark words written since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // Register read data; unwritten words read as zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/abe_mask.sv @@
// Shift unit that builds the bit mask of one word for a command's span.
`default_nettype none

module abe_mask (
  input  wire abe_pkg::mask_ctl_t ctl,
  input  wire abe_pkg::widx_t     word_idx,
  output abe_pkg::word_t          mask
);

  abe_pkg::bidx_t lo_eff;
  abe_pkg::bidx_t hi_eff;

  // Apply edge offsets only on the first and last words of the span.
  always_comb begin
    lo_eff = (word_idx == ctl.first) ? ctl.lo : '0;
    hi_eff = (word_idx == ctl.last) ? ctl.hi : abe_pkg::bidx_t'(abe_pkg::WORD_BITS - 1);
  end

  // Offset o maps to bit WORD_BITS-1-o, so keep bits from lo down to hi.
  assign mask = ({abe_pkg::WORD_BITS{1'b1}} >> lo_eff)
              & ({abe_pkg::WORD_BITS{1'b1}}
                 << (abe_pkg::bidx_t'(abe_pkg::WORD_BITS - 1) - hi_eff));

endmodule

`default_nettype wire

@@ rtl/abe_tz.sv @@
// Iterative trailing-zero counter, one binary-search step per cycle.
`default_nettype none

module abe_tz (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire abe_pkg::word_t word,
  output logic                done,
  output abe_pkg::bidx_t      count
);

  localparam logic [abe_pkg::STEP_W-1:0] LastStep = abe_pkg::STEP_W'(abe_pkg::BIDX_W - 1);

  abe_pkg::word_t                w;
  logic [abe_pkg::STEP_W-1:0]    step;
  logic                          run;
  abe_pkg::bidx_t                half;
  logic                          low_zero;

  // Halve the window each step: 32, 16, ... 1 bits for a 64-bit word.
  always_comb begin
    half     = abe_pkg::bidx_t'(1) << (LastStep - step);
    low_zero = (w & ~({abe_pkg::WORD_BITS{1'b1}} << half)) == '0;
  end

  // Advance the step counter and flag completion.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= run && (step == LastStep);
      if (load) begin
        run  <= 1'b1;
        step <= '0;
      end else if (run) begin
        step <= step + 1'b1;
        if (step == LastStep) begin
          run <= 1'b0;
        end
      end
    end
  end

  // Drop empty low halves and add their width to the count.
  always_ff @(posedge clk) begin
    if (load) begin
      w     <= word;
      count <= '0;
    end else if (run && low_zero) begin
      w     <= w >> half;
      count <= count + half;
    end
  end

endmodule

`default_nettype wire

@@ sim/tb_allocation_bitmap_engine.sv @@
// Self-checking testbench for the allocation bitmap engine: directed rows, then random commands.
module tb_allocation_bitmap_engine;
  import abe_pkg::*;

  localparam int   RANDOM_WORDS = 1900;
  localparam int   STALL_LIMIT  = 2000;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   POS_MAX      = (1 << POS_W) - 1;
  localparam cmd_t CMD_UNUSED   = 3'd7;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  want;
  } dir_row_t;

  logic     clk     = 1'b0;
  logic     rst     = 1'b1;
  logic     start   = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  // Mirror of the bitmap, MSB-first within each word
  word_t    map_words [WORD_COUNT];
  result_t  pending_results [$];
  dir_row_t dir_rows [$];
  bit       cur_typed   = 1'b0;
  result_t  cur_want    = '0;
  int       error_count = 0;
  int       idle_cycles = 0;

  allocation_bitmap_engine dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic bit map_bit(int p);
    return map_words[p / WORD_BITS][WORD_BITS - 1 - (p % WORD_BITS)];
  endfunction

  function automatic void write_map_bit(int p, bit v);
    map_words[p / WORD_BITS][WORD_BITS - 1 - (p % WORD_BITS)] = v;
  endfunction

  // Apply one command to the mirror and return the result word it should produce
  function automatic result_t apply_command(request_t r);
    result_t res;
    int      s;
    int      e;
    bit      old_bit;
    res = '0;
    s = (r.start_position > MAP_BITS) ? MAP_BITS : int'(r.start_position);
    e = (r.end_position > MAP_BITS) ? MAP_BITS : int'(r.end_position);
    case (r.command)
      CMD_TEST_BIT, CMD_SET_BIT, CMD_CLEAR_BIT: begin
        if (r.start_position >= MAP_BITS) begin
          res.position_error = 1'b1;
        end else begin
          old_bit = map_bit(s);
          if (r.command == CMD_TEST_BIT) begin
            res.flag = old_bit;
          end else begin
            res.flag = (old_bit != (r.command == CMD_SET_BIT));
            write_map_bit(s, r.command == CMD_SET_BIT);
          end
        end
      end
      CMD_SET_RANGE, CMD_CLEAR_RANGE: begin
        for (int p = s; p < e; p++) write_map_bit(p, r.command == CMD_SET_RANGE);
      end
      CMD_ZERO_TEST: begin
        res.flag = 1'b1;
        for (int p = s; p < e; p++) if (map_bit(p)) res.flag = 1'b0;
      end
      CMD_FIND_LAST: begin
        for (int p = MAP_BITS; p > 0; p--) begin
          if (res.found_position == '0 && map_bit(p - 1)) res.found_position = pos_t'(p);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH @%0t: %s", $time, what);
    error_count++;
  endtask

  // Compare one result word with the oldest pending one
  task automatic check_result(result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch($sformatf("result word with nothing pending: %p", got));
      return;
    end
    want = pending_results.pop_front();
    if (got.flag !== want.flag)
      report_mismatch($sformatf("flag got %b want %b", got.flag, want.flag));
    if (got.found_position !== want.found_position)
      report_mismatch($sformatf("found_position got %0d want %0d",
                                got.found_position, want.found_position));
    if (got.position_error !== want.position_error)
      report_mismatch($sformatf("position_error got %b want %b",
                                got.position_error, want.position_error));
  endtask

  // Sample results and accepted commands at the rising edge
  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst) begin
      if (done) check_result(result);
      if (start && !busy) begin
        want = apply_command(request);
        if (cur_typed) want = cur_want;
        pending_results.push_back(want);
      end
    end
  end

  // Count cycles with no traffic; give up at the limit
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("allocation_bitmap_engine verification failed");
      $finish;
    end
  end

  // Hold off for gap cycles, then present one word until the block takes it
  task automatic send_word(request_t r, bit typed, result_t want, int gap);
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start     = 1'b1;
    request   = r;
    cur_typed = typed;
    cur_want  = want;
    do @(posedge clk); while (busy);
  endtask

  function automatic dir_row_t mk_row(cmd_t c, int s, int e, bit typed,
                                      bit f, int found, bit err);
    dir_row_t row;
    row.req.command        = c;
    row.req.start_position = pos_t'(s);
    row.req.end_position   = pos_t'(e);
    row.typed              = typed;
    row.want.flag           = f;
    row.want.found_position = pos_t'(found);
    row.want.position_error = err;
    return row;
  endfunction

  // Draw a random command word, mostly in-map positions and short ranges
  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       s;
    int       e;
    pick = $urandom_range(0, 99);
    if (pick < 14)      r.command = CMD_TEST_BIT;
    else if (pick < 28) r.command = CMD_SET_BIT;
    else if (pick < 40) r.command = CMD_CLEAR_BIT;
    else if (pick < 54) r.command = CMD_SET_RANGE;
    else if (pick < 67) r.command = CMD_CLEAR_RANGE;
    else if (pick < 83) r.command = CMD_ZERO_TEST;
    else if (pick < 97) r.command = CMD_FIND_LAST;
    else                r.command = CMD_UNUSED;
    if ($urandom_range(0, 9) == 0) s = $urandom_range(MAP_BITS, POS_MAX);
    else                           s = $urandom_range(0, MAP_BITS - 1);
    case ($urandom_range(0, 9))
      0:       e = $urandom_range(0, POS_MAX);
      1:       e = s - $urandom_range(0, 3);
      2:       e = s + $urandom_range(0, MAP_BITS - 1);
      default: e = s + $urandom_range(1, 70);
    endcase
    if (e < 0) e = 0;
    if (e > POS_MAX) e = POS_MAX;
    r.start_position = pos_t'(s);
    r.end_position   = pos_t'(e);
    return r;
  endfunction

  initial begin : stimulus
    bit no_gaps;
    foreach (map_words[i]) map_words[i] = '0;

    // Directed rows: empty map, out-of-map bits, map edges, empty and saturated ranges
    dir_rows.push_back(mk_row(CMD_FIND_LAST,   0,    0,    1, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_TEST_BIT,    0,    0,    1, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_ZERO_TEST,   0,    2047, 1, 1, 0,    0));
    dir_rows.push_back(mk_row(CMD_TEST_BIT,    1024, 0,    1, 0, 0,    1));
    dir_rows.push_back(mk_row(CMD_SET_BIT,     2047, 5,    1, 0, 0,    1));
    dir_rows.push_back(mk_row(CMD_CLEAR_BIT,   1024, 0,    1, 0, 0,    1));
    dir_rows.push_back(mk_row(CMD_SET_BIT,     0,    0,    1, 1, 0,    0));
    dir_rows.push_back(mk_row(CMD_SET_BIT,     0,    0,    1, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_TEST_BIT,    0,    0,    1, 1, 0,    0));
    dir_rows.push_back(mk_row(CMD_FIND_LAST,   0,    0,    1, 0, 1,    0));
    dir_rows.push_back(mk_row(CMD_SET_BIT,     1023, 0,    1, 1, 0,    0));
    dir_rows.push_back(mk_row(CMD_FIND_LAST,   0,    0,    1, 0, 1024, 0));
    dir_rows.push_back(mk_row(CMD_CLEAR_BIT,   1023, 0,    1, 1, 0,    0));
    dir_rows.push_back(mk_row(CMD_CLEAR_BIT,   1023, 0,    1, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_SET_RANGE,   60,   70,   1, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_ZERO_TEST,   64,   65,   0, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_FIND_LAST,   0,    0,    0, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_ZERO_TEST,   70,   2047, 1, 1, 0,    0));
    dir_rows.push_back(mk_row(CMD_SET_RANGE,   500,  500,  1, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_ZERO_TEST,   10,   3,    1, 1, 0,    0));
    dir_rows.push_back(mk_row(CMD_ZERO_TEST,   5,    0,    1, 1, 0,    0));
    dir_rows.push_back(mk_row(CMD_SET_RANGE,   0,    2047, 1, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_FIND_LAST,   0,    0,    1, 0, 1024, 0));
    dir_rows.push_back(mk_row(CMD_ZERO_TEST,   2047, 2047, 1, 1, 0,    0));
    dir_rows.push_back(mk_row(CMD_CLEAR_RANGE, 1,    1024, 1, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_FIND_LAST,   0,    0,    1, 0, 1,    0));
    dir_rows.push_back(mk_row(CMD_UNUSED,      2047, 2047, 1, 0, 0,    0));
    dir_rows.push_back(mk_row(CMD_CLEAR_RANGE, 0,    2047, 1, 0, 0,    0));

    // Hold reset, then release at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_word(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want, $urandom_range(0, 14));

    // Random commands, with back-to-back stretches mixed in
    no_gaps = 1'b0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_word(random_request(), 1'b0, '0, no_gaps ? 0 : $urandom_range(0, 14));
    end
    @(negedge clk);
    start = 1'b0;

    // Drain outstanding results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("allocation_bitmap_engine verification clean");
    end else begin
      $display("allocation_bitmap_engine verification failed");
    end
    $finish;
  end

endmodule
